/* rtl/core/srtm_pkg.sv */
`timescale 1ns / 1ps

package srtm_pkg;

  localparam int unsigned NumSlots = 3;
  localparam int unsigned SlotIdxW = $clog2(NumSlots + 1);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef logic signed [63:0] row_t;

  typedef struct packed {
    logic partial;
    row_t rng_start;
    row_t rng_end;
    logic err;
  } result_t;

  typedef struct packed {
    logic [SlotIdxW-1:0]         cnt;
    result_t [NumSlots-1:0]      res;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t bundle;
  } q_push_t;

  typedef struct packed {
    logic    pop;
  } q_pop_t;

  typedef struct packed {
    logic    full;
    logic    empty;
    bundle_t head;
  } q_status_t;

endpackage

/* rtl/core/srtm_front.sv */
`timescale 1ns / 1ps

module srtm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                range_partial_i,
  input  srtm_pkg::row_t      range_start_i,
  input  srtm_pkg::row_t      range_end_i,
  input  logic                flush_i,
  input  logic                q_full_i,
  output srtm_pkg::q_push_t   q_push_o
);
  import srtm_pkg::*;

  logic    tail_valid_q, tail_valid_d;
  logic    tail_partial_q, tail_partial_d;
  row_t    tail_start_q, tail_start_d;
  row_t    tail_end_q, tail_end_d;
  logic    accept;
  bundle_t bundle;
  logic [SlotIdxW-1:0] n;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    bundle         = '0;
    n              = '0;
    tail_valid_d   = tail_valid_q;
    tail_partial_d = tail_partial_q;
    tail_start_d   = tail_start_q;
    tail_end_d     = tail_end_q;
    if (!(range_start_i < range_end_i)) begin
    end else if (!tail_valid_q) begin
      tail_valid_d   = 1'b1;
      tail_partial_d = range_partial_i;
      tail_start_d   = range_start_i;
      tail_end_d     = range_end_i;
    end else if (range_start_i < tail_start_q) begin
      bundle.res[n] = '{partial: 1'b0, rng_start: '0, rng_end: '0, err: 1'b1};
      n             = n + 1'b1;
    end else if (tail_end_q < range_start_i) begin
      bundle.res[n] = '{partial: tail_partial_q, rng_start: tail_start_q,
                        rng_end: tail_end_q, err: 1'b0};
      n             = n + 1'b1;
      tail_partial_d = range_partial_i;
      tail_start_d   = range_start_i;
      tail_end_d     = range_end_i;
    end else if (tail_end_q < range_end_i) begin
      if (tail_partial_q == range_partial_i) begin
        tail_end_d = range_end_i;
      end else if (range_partial_i) begin
        bundle.res[n] = '{partial: tail_partial_q, rng_start: tail_start_q,
                          rng_end: tail_end_q, err: 1'b0};
        n              = n + 1'b1;
        tail_partial_d = 1'b1;
        tail_start_d   = tail_end_q;
        tail_end_d     = range_end_i;
      end else begin
        if (tail_start_q < range_start_i) begin
          bundle.res[n] = '{partial: 1'b1, rng_start: tail_start_q,
                            rng_end: range_start_i, err: 1'b0};
          n             = n + 1'b1;
        end
        tail_partial_d = 1'b0;
        tail_start_d   = range_start_i;
        tail_end_d     = range_end_i;
      end
    end else if (tail_partial_q && !range_partial_i) begin
      // split a partial tail around a full range
      if (tail_start_q < range_start_i) begin
        bundle.res[n] = '{partial: 1'b1, rng_start: tail_start_q,
                          rng_end: range_start_i, err: 1'b0};
        n             = n + 1'b1;
      end
      if (range_end_i < tail_end_q) begin
        bundle.res[n] = '{partial: 1'b0, rng_start: range_start_i,
                          rng_end: range_end_i, err: 1'b0};
        n              = n + 1'b1;
        tail_partial_d = 1'b1;
        tail_start_d   = range_end_i;
        tail_end_d     = tail_end_q;
      end else begin
        tail_partial_d = 1'b0;
        tail_start_d   = range_start_i;
        tail_end_d     = range_end_i;
      end
    end
    if (flush_i && tail_valid_d) begin
      bundle.res[n] = '{partial: tail_partial_d, rng_start: tail_start_d,
                        rng_end: tail_end_d, err: 1'b0};
      n              = n + 1'b1;
      tail_valid_d   = 1'b0;
      tail_partial_d = 1'b0;
      tail_start_d   = '0;
      tail_end_d     = '0;
    end
    bundle.cnt = n;
  end

  assign q_push_o.push   = accept && (n != '0);
  assign q_push_o.bundle = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_valid_q   <= 1'b0;
      tail_partial_q <= 1'b0;
      tail_start_q   <= '0;
      tail_end_q     <= '0;
    end else if (accept) begin
      tail_valid_q   <= tail_valid_d;
      tail_partial_q <= tail_partial_d;
      tail_start_q   <= tail_start_d;
      tail_end_q     <= tail_end_d;
    end
  end

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && flush_i |=> !tail_valid_q)
    else $error("tail still pending after flush");

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o.push |-> (q_push_o.bundle.cnt != '0) && !q_full_i)
    else $error("empty or blocked bundle pushed");

  a_tail_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_valid_q |-> tail_start_q < tail_end_q)
    else $error("pending tail is empty");

endmodule

/* rtl/core/srtm_queue.sv */
`timescale 1ns / 1ps

module srtm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srtm_pkg::q_push_t     push_i,
  input  srtm_pkg::q_pop_t      pop_i,
  output srtm_pkg::q_status_t   status_o
);
  import srtm_pkg::*;

  bundle_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign status_o.head  = mem_q[rd_ptr_q];
  assign do_push        = push_i.push && !status_o.full;
  assign do_pop         = pop_i.pop && !status_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.bundle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count overrun");

endmodule

/* rtl/core/srtm_back.sv */
`timescale 1ns / 1ps

module srtm_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srtm_pkg::q_status_t   q_status_i,
  output srtm_pkg::q_pop_t      q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_partial_o,
  output srtm_pkg::row_t        out_start_o,
  output srtm_pkg::row_t        out_end_o,
  output logic                  order_error_o,
  output logic                  out_last_o
);
  import srtm_pkg::*;

  logic [SlotIdxW-1:0] idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  result_t             res_q;
  logic                last_q;
  logic                load, is_last;
  result_t             cur;

  assign load    = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign cur     = q_status_i.head.res[idx_q];
  assign is_last = (idx_q == q_status_i.head.cnt - 1'b1);
  assign q_pop_o.pop = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= cur;
      last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_partial_o = res_q.partial;
  assign out_start_o   = res_q.rng_start;
  assign out_end_o     = res_q.rng_end;
  assign order_error_o = res_q.err;
  assign out_last_o    = last_q;

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> idx_q < q_status_i.head.cnt)
    else $error("slot index beyond bundle");

  a_idx_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o.pop |=> idx_q == '0)
    else $error("slot index not rewound after pop");

endmodule

/* rtl/core/sorted_range_tail_merger.sv */
`timescale 1ns / 1ps
// A range beat's results pass through the bundle queue, then the output register.
// Throughput: one range beat per cycle while the queue is not full; results
// leave at one beat per cycle while out_stall_i is low, k results as k beats.
// The two-entry bundle queue stalls the input only when full.
// Reset (rst_ni low, asynchronous): no pending tail, queue empty, output idle.
module sorted_range_tail_merger (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           range_partial_i,
  input  srtm_pkg::row_t range_start_i,
  input  srtm_pkg::row_t range_end_i,
  input  logic           flush_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           out_partial_o,
  output srtm_pkg::row_t out_start_o,
  output srtm_pkg::row_t out_end_o,
  output logic           order_error_o,
  output logic           out_last_o
);
  import srtm_pkg::*;

  q_push_t   q_push;
  q_pop_t    q_pop;
  q_status_t q_status;

  srtm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .range_partial_i (range_partial_i),
    .range_start_i   (range_start_i),
    .range_end_i     (range_end_i),
    .flush_i         (flush_i),
    .q_full_i        (q_status.full),
    .q_push_o        (q_push)
  );

  srtm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .pop_i    (q_pop),
    .status_o (q_status)
  );

  srtm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_partial_o (out_partial_o),
    .out_start_o   (out_start_o),
    .out_end_o     (out_end_o),
    .order_error_o (order_error_o),
    .out_last_o    (out_last_o)
  );

endmodule
